// ===== design/lncc_pkg.sv =====
// Package for the line NCC match score block: widths, payload and command types.
// Used by every module of the block; depends on nothing.
package lncc_pkg;

   localparam int MAX_LINE_LEN = 32;
   localparam int CNT_W = $clog2(MAX_LINE_LEN + 1);
   localparam int SUM_W = $clog2(MAX_LINE_LEN * 255 + 1);
   localparam int SQ_W = $clog2(MAX_LINE_LEN * 65025 + 1);
   localparam int V_W = CNT_W + SQ_W;
   localparam int FRAC_W = 16;
   localparam int DIV_STEPS = FRAC_W;
   localparam int STEP_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [7:0] template_pixel;
      logic [7:0] image_pixel;
      logic outside_image;
      logic is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] match_score;
      logic score_zeroed;
   } rsp_payload_type;

   typedef struct packed {
      logic acc_en;
      logic clear;
      logic prod_en;
      logic var_en;
      logic prep_en;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

endpackage

// ===== design/lncc_ctrl.sv =====
// Controller for the line NCC block: sequences accumulate, products, divide, output.
// Depends on lncc_pkg.
module lncc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_is_last,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output lncc_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_VAR,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic [lncc_pkg::STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_beat;
   logic out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.acc_en = req_beat;
            if (req_beat && req_is_last) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod_en = 1'b1;
            state_in = ST_VAR;
         end
         ST_VAR: begin
            cmd.var_en = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep_en = 1'b1;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == lncc_pkg::STEP_W'(lncc_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/lncc_datapath.sv =====
// Datapath for the line NCC block: line sums, variance terms, restoring divider.
// Depends on lncc_pkg; driven by lncc_ctrl commands.
module lncc_datapath (
   input  logic clock,
   input  logic reset,
   input  lncc_pkg::dp_cmd_type cmd,
   input  lncc_pkg::req_payload_type req_data,
   output lncc_pkg::rsp_payload_type rsp_data
);

   localparam int CW = lncc_pkg::CNT_W;
   localparam int SW = lncc_pkg::SUM_W;
   localparam int QW = lncc_pkg::SQ_W;
   localparam int VW = lncc_pkg::V_W;
   localparam int FW = lncc_pkg::FRAC_W;

   logic [CW-1:0] cnt_ff;
   logic [SW-1:0] sa_ff, sb_ff;
   logic [QW-1:0] sa2_ff, sb2_ff, sab_ff;
   logic oob_ff;

   logic [VW-1:0] p_na2_ff, p_nb2_ff, p_nab_ff;
   logic [VW-1:0] p_a2_ff, p_b2_ff, p_ab_ff;
   logic [VW-1:0] va_ff, vb_ff;
   logic signed [VW:0] c_ff;

   logic [VW+1:0] rem_ff, rem_in;
   logic [VW:0] den_ff;
   logic [FW-1:0] quot_ff;
   logic neg_ff, zero_ff;
   lncc_pkg::rsp_payload_type out_ff;

   logic [VW-1:0] vmax, mag;
   logic [VW+FW:0] num;
   logic [VW+1:0] trial;
   logic take;
   logic [FW-1:0] pos_q, neg_q;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         cnt_ff <= '0;
         sa_ff <= '0;
         sb_ff <= '0;
         sa2_ff <= '0;
         sb2_ff <= '0;
         sab_ff <= '0;
         oob_ff <= 1'b0;
      end else if (cmd.acc_en) begin
         oob_ff <= oob_ff | req_data.outside_image;
         if (cnt_ff < CW'(lncc_pkg::MAX_LINE_LEN)) begin
            cnt_ff <= cnt_ff + 1'b1;
            sa_ff <= sa_ff + SW'(req_data.template_pixel);
            sb_ff <= sb_ff + SW'(req_data.image_pixel);
            sa2_ff <= sa2_ff + QW'(req_data.template_pixel) * QW'(req_data.template_pixel);
            sb2_ff <= sb2_ff + QW'(req_data.image_pixel) * QW'(req_data.image_pixel);
            sab_ff <= sab_ff + QW'(req_data.template_pixel) * QW'(req_data.image_pixel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prod_en) begin
         p_na2_ff <= VW'(cnt_ff) * VW'(sa2_ff);
         p_nb2_ff <= VW'(cnt_ff) * VW'(sb2_ff);
         p_nab_ff <= VW'(cnt_ff) * VW'(sab_ff);
         p_a2_ff <= VW'(sa_ff) * VW'(sa_ff);
         p_b2_ff <= VW'(sb_ff) * VW'(sb_ff);
         p_ab_ff <= VW'(sa_ff) * VW'(sb_ff);
      end
      if (cmd.var_en) begin
         va_ff <= p_na2_ff - p_a2_ff;
         vb_ff <= p_nb2_ff - p_b2_ff;
         c_ff <= $signed({1'b0, p_nab_ff}) - $signed({1'b0, p_ab_ff});
      end
   end

   // numerator is |C| * 2^16 + vmax, divisor 2 * vmax; quotient stays below 2^16
   assign vmax = (va_ff > vb_ff) ? va_ff : vb_ff;
   assign mag = c_ff[VW] ? VW'(-c_ff) : VW'(c_ff);
   assign num = {1'b0, mag, {FW{1'b0}}} + (VW + FW + 1)'(vmax);
   assign trial = {rem_ff[VW:0], quot_ff[FW-1]};
   assign take = trial >= (VW + 2)'(den_ff);
   assign rem_in = take ? trial - (VW + 2)'(den_ff) : trial;

   always_ff @(posedge clock) begin
      if (cmd.prep_en) begin
         rem_ff <= (VW + 2)'(num[VW+FW:FW]);
         quot_ff <= num[FW-1:0];
         den_ff <= {vmax, 1'b0};
         neg_ff <= c_ff[VW];
         zero_ff <= oob_ff || (va_ff == '0) || (vb_ff == '0);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quot_ff <= {quot_ff[FW-2:0], take};
      end
   end

   // clamp to +32767 / -32768
   assign pos_q = quot_ff[FW-1] ? {1'b0, {(FW - 1){1'b1}}} : quot_ff;
   assign neg_q = quot_ff[FW-1] ? {1'b1, {(FW - 1){1'b0}}} : FW'(-quot_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff.score_zeroed <= zero_ff;
         if (zero_ff) begin
            out_ff.match_score <= '0;
         end else if (neg_ff) begin
            out_ff.match_score <= $signed(neg_q);
         end else begin
            out_ff.match_score <= $signed(pos_q);
         end
      end
   end

   assign rsp_data = out_ff;

endmodule

// ===== design/line_ncc_match_score_top.sv =====
// After the beat that carries is_last, the block steps through products,
// variance terms, prep, the 16-step divider and output load before rsp_valid.
// One pixel pair per cycle within a line; no new pairs are taken from the
// is_last beat until the result is loaded. A result waits in the output register.
// Reset (synchronous, active high) clears the line sums and drops rsp_valid.
module line_ncc_match_score_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  lncc_pkg::req_payload_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output lncc_pkg::rsp_payload_type rsp_data
);

   lncc_pkg::dp_cmd_type cmd;

   lncc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_is_last(req_data.is_last),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd(cmd)
   );

   lncc_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

endmodule

// ===== design/lncc_checker.sv =====
// Port-level checker for line_ncc_match_score_top, bound to the top level.
// Depends on lncc_pkg.
module lncc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input lncc_pkg::req_payload_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input lncc_pkg::rsp_payload_type rsp_data
);

   // a pending beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_zero_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.score_zeroed |-> rsp_data.match_score == 16'sd0)
      else $error("zeroed result with nonzero score");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.is_last |=> !req_ready)
      else $error("input taken during end-of-line compute");

endmodule

bind line_ncc_match_score_top lncc_checker u_lncc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);

// ===== tb/tb_checker.sv =====
// Scoreboard for the line NCC match score block: predicts each line's score and
// compares result beats in order. Depends on lncc_pkg.
`timescale 1ns / 100ps

module tb_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  lncc_pkg::req_payload_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  lncc_pkg::rsp_payload_type rsp_data,
   output int   fail_count,
   output int   pending_scores
);

   lncc_pkg::rsp_payload_type score_queue[$];
   int unsigned n_pairs;
   longint unsigned sum_t, sum_t2, sum_i, sum_i2, sum_ti;
   bit oob_seen;
   int mismatches;

   function automatic lncc_pkg::rsp_payload_type line_score();
      lncc_pkg::rsp_payload_type r;
      longint signed va, vb, vmax, c, mag, q;
      begin
         va = n_pairs * sum_t2 - sum_t * sum_t;
         vb = n_pairs * sum_i2 - sum_i * sum_i;
         c = longint'(n_pairs * sum_ti) - longint'(sum_t * sum_i);
         r.match_score = '0;
         r.score_zeroed = 1'b1;
         if (!oob_seen && va != 0 && vb != 0) begin
            r.score_zeroed = 1'b0;
            vmax = (va > vb) ? va : vb;
            mag = (c < 0) ? -c : c;
            q = (mag * 65536 + vmax) / (2 * vmax);
            if (c < 0) begin
               if (q > 32768) q = 32768;
               r.match_score = 16'(-q);
            end else begin
               if (q > 32767) q = 32767;
               r.match_score = 16'(q);
            end
         end
         return r;
      end
   endfunction

   assign pending_scores = score_queue.size();

   always @(posedge clock) begin
      lncc_pkg::rsp_payload_type exp_r;
      if (reset) begin
         sum_t = 0; sum_t2 = 0; sum_i = 0; sum_i2 = 0; sum_ti = 0;
         oob_seen = 0;
         n_pairs = 0;
         score_queue.delete();
         fail_count <= 0;
         mismatches = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.outside_image) oob_seen = 1;
            if (n_pairs < lncc_pkg::MAX_LINE_LEN) begin
               sum_t += req_data.template_pixel;
               sum_t2 += req_data.template_pixel * req_data.template_pixel;
               sum_i += req_data.image_pixel;
               sum_i2 += req_data.image_pixel * req_data.image_pixel;
               sum_ti += req_data.template_pixel * req_data.image_pixel;
               n_pairs++;
            end
            if (req_data.is_last) begin
               score_queue.push_back(line_score());
               sum_t = 0; sum_t2 = 0; sum_i = 0; sum_i2 = 0; sum_ti = 0;
               oob_seen = 0;
               n_pairs = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (score_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected score beat: %0d zeroed %0b",
                     rsp_data.match_score, rsp_data.score_zeroed);
            end else begin
               exp_r = score_queue.pop_front();
               if (exp_r !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("score mismatch: exp %0d/%0b got %0d/%0b",
                        exp_r.match_score, exp_r.score_zeroed,
                        rsp_data.match_score, rsp_data.score_zeroed);
               end
            end
         end
         fail_count <= mismatches;
      end
   end
endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the line NCC match score block; uses tb_checker
// for prediction and lncc_pkg for the payload types.
`timescale 1ns / 100ps

module tb_top;

   localparam int IDLE_LIMIT = 20000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   lncc_pkg::req_payload_type req_data;
   lncc_pkg::rsp_payload_type rsp_data;
   int fail_count, pending_scores;
   int idle_cycles;
   int stall_mode;

   line_ncc_match_score_top dut (.*);
   tb_checker chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // receiver stall pattern: modes switch every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 40) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_pair(input lncc_pkg::req_payload_type p);
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      // random gap after a burst
      if ($urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_line(input int len, input int mode);
      lncc_pkg::req_payload_type p;
      int base_t, base_i, k;
      base_t = $urandom_range(0, 255);
      base_i = $urandom_range(0, 255);
      k = $urandom_range(0, 3);
      for (int j = 0; j < len; j++) begin
         p.template_pixel = $urandom_range(0, 255);
         p.image_pixel = $urandom_range(0, 255);
         case (mode)
            1: p.image_pixel = p.template_pixel;            // perfect match
            2: p.image_pixel = 8'(255 - p.template_pixel);  // inverted
            3: p.template_pixel = 8'(base_t);               // flat template
            4: p.image_pixel = 8'(base_i);                  // flat image
            5: p.image_pixel = 8'((p.template_pixel >> k) + base_i / 2);
            default: ;
         endcase
         p.outside_image = (mode == 6) ? ($urandom_range(0, 9) == 0) : 1'b0;
         p.is_last = (j == len - 1);
         send_pair(p);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_scores != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      lncc_pkg::req_payload_type p;
      int sent, len;
      req_valid = 0;
      req_data = '0;
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed lines
      send_line(1, 0);
      send_line(2, 1);
      send_line(32, 1);
      send_line(32, 2);
      send_line(5, 3);
      send_line(5, 4);
      send_line(4, 6);
      p = '{8'hFF, 8'h00, 1'b1, 1'b0}; send_pair(p);
      p = '{8'h00, 8'hFF, 1'b0, 1'b1}; send_pair(p);
      p = '{8'hFF, 8'hFF, 1'b0, 1'b0}; send_pair(p);
      p = '{8'h00, 8'h00, 1'b0, 1'b1}; send_pair(p);
      send_line(40, 0);  // too long: tail pairs dropped
      drain();
      sent = 0;
      while (sent < 1525) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 45)
                                           : $urandom_range(1, 32);
         send_line(len, $urandom_range(0, 6));
         sent += len;
         if ($urandom_range(0, 30) == 0) drain();
      end
      drain();
      if (fail_count == 0 && pending_scores == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

// ===== line_ncc_match_score_top.f =====
design/lncc_pkg.sv
design/lncc_ctrl.sv
design/lncc_datapath.sv
design/line_ncc_match_score_top.sv
design/lncc_checker.sv
tb/tb_checker.sv
tb/tb_top.sv
